/* sv/tpdq_pkg.sv */
// ----------------------------------------------------------------------------
// tpdq_pkg: shared types and codes of the two-priority DMA request queue
// Holds the queue entry layout, the cell operation codes and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned SizeW      = 25;

  // Input item kinds carried on the slave tuser.
  typedef enum logic [2:0] {
    ACT_POST         = 3'd0,
    ACT_SERVICE      = 3'd1,
    ACT_REMOVE_TAG   = 3'd2,
    ACT_REMOVE_OWNER = 3'd3,
    ACT_FLUSH        = 3'd4
  } action_e;

  // Result status carried on the master tuser.
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_BAD_XFR = 3'd4
  } status_e;

  // Operation broadcast to every cell of the row at once.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_MARK_TAG,
    CELL_MARK_OWNER,
    CELL_CLEAR,
    CELL_COMPACT
  } cell_op_e;

  typedef struct packed {
    logic [15:0]      tag;
    logic [31:0]      owner;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [SizeW-1:0] len;
    logic             dir;
    logic             prio;
    logic             notify;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   keep;
    logic   hole;
    entry_t entry;
  } link_t;

endpackage

`default_nettype wire

/* sv/tpdq_cell.sv */
// ----------------------------------------------------------------------------
// tpdq_cell: one queue slot of the request row
// Holds one entry and its valid bit and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tpdq_pkg::cell_cmd_t    cmd_i,
  input  tpdq_pkg::link_t        left_i,
  input  tpdq_pkg::link_t        right_i,
  output tpdq_pkg::link_t        cell_o,
  output logic                   gap_o,
  output logic                   boundary_o
);

  logic            valid_q, valid_d;
  tpdq_pkg::entry_t entry_q, entry_d;
  logic            keep;
  logic            shift_in;

  // An entry stays put on insert if it is ahead of the new request's place.
  assign keep     = valid_q & (~cmd_i.entry.prio | entry_q.prio);
  assign shift_in = left_i.hole | ~valid_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    case (cmd_i.op)
      tpdq_pkg::CELL_INSERT: begin
        if (!keep) begin
          if (left_i.keep) begin
            valid_d = 1'b1;
            entry_d = cmd_i.entry;
          end else begin
            valid_d = left_i.valid;
            entry_d = left_i.entry;
          end
        end
      end
      tpdq_pkg::CELL_POP: begin
        valid_d = right_i.valid;
        entry_d = right_i.entry;
      end
      tpdq_pkg::CELL_MARK_TAG: begin
        if (entry_q.tag == cmd_i.entry.tag) valid_d = 1'b0;
      end
      tpdq_pkg::CELL_MARK_OWNER: begin
        if (entry_q.owner == cmd_i.entry.owner) valid_d = 1'b0;
      end
      tpdq_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      tpdq_pkg::CELL_COMPACT: begin
        if (shift_in) begin
          valid_d = right_i.valid;
          entry_d = right_i.entry;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.keep  = keep;
  assign cell_o.hole  = shift_in;
  assign cell_o.entry = entry_q;

  // A valid entry behind a hole means the row still needs compaction.
  assign gap_o      = left_i.hole & valid_q;
  assign boundary_o = ~left_i.hole & ~valid_q;

endmodule

`default_nettype wire

/* sv/tpdq_chain.sv */
// ----------------------------------------------------------------------------
// tpdq_chain: the row of queue cells
// Links the cells head to tail and reports the head entry and fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdq_chain (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  tpdq_pkg::cell_cmd_t                cmd_i,
  output tpdq_pkg::entry_t                   head_o,
  output logic                               gap_o,
  output logic [tpdq_pkg::CountW-1:0]        fill_o
);

  localparam int unsigned Depth = tpdq_pkg::QueueDepth;

  tpdq_pkg::link_t          link   [Depth+1];
  tpdq_pkg::link_t          right  [Depth];
  logic [Depth-1:0]         gap;
  logic [Depth-1:0]         boundary;

  // Virtual cell ahead of the head: the new entry lands at the head if
  // nothing stays ahead of it, and no hole lies before the head.
  assign link[0].valid = 1'b0;
  assign link[0].keep  = 1'b1;
  assign link[0].hole  = 1'b0;
  assign link[0].entry = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == Depth - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = link[i+2];
    end

    tpdq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .left_i    (link[i]),
      .right_i   (right[i]),
      .cell_o    (link[i+1]),
      .gap_o     (gap[i]),
      .boundary_o(boundary[i])
    );
  end

  assign head_o = link[1].entry;
  assign gap_o  = |gap;

  // Once the row is compact, the only boundary cell is the first empty one.
  always_comb begin
    fill_o = (|boundary) ? '0 : tpdq_pkg::CountW'(Depth);
    for (int i = 0; i < Depth; i++) begin
      if (boundary[i]) fill_o = fill_o | tpdq_pkg::CountW'(i);
    end
  end

endmodule

`default_nettype wire

/* sv/two_priority_dma_request_queue.sv */
// ----------------------------------------------------------------------------
// two_priority_dma_request_queue: DMA request queue with two priorities
// Queues transfer requests in a row of cells and pops, checks and reports them.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the slave stream. tuser carries the action (post,
//   service the head, remove by tag, remove by owner, flush) and tdata the
//   request fields. Every accepted transfer yields exactly one result on the
//   master stream: tuser carries the status, tdata the popped request with its
//   resolved RAM offset and host address, plus the occupancy after the item.
//   The cfg channel writes the RAM size used for the bounds checks; it is
//   always ready and must only be written while the block is idle.
// Sequencing
//   A post, a service or a flush goes from idle through the execute state to
//   the result state, which writes the result register when it is free; the
//   slave side takes the next transfer only once the block is back in idle.
//   A removal by tag or owner clears the matching cells in the execute state
//   and then compacts the row one slot per cycle until no valid entry sits
//   behind a hole, and only then moves on to the result state. One item is
//   in work at a time; the next transfer is taken as soon as the block is back
//   in idle, even while the previous result still waits in the output register.
// Reset and stall
//   Reset empties the queue, drops any pending result and restores the full
//   RAM size. A stalled receiver holds the result register; the block then
//   finishes at most one more item and waits until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_priority_dma_request_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Slave request stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata, low bit first: request_tag[15:0], owner_id[47:16], direction[48],
  // priority_req[49], source_address[81:50], dest_address[113:82],
  // length[138:114], notify_wanted[139], zero fill [143:140].
  input  wire logic [143:0] s_axis_tdata,
  // tuser: action[2:0].
  input  wire logic [2:0]   s_axis_tuser,
  // Master result stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata, low bit first: transfer_valid[0], out_tag[16:1], out_direction[17],
  // ram_offset[49:18], host_address[81:50], out_length[106:82],
  // completion_notify[107], occupancy[112:108], zero fill [119:113].
  output logic [119:0]      m_axis_tdata,
  // tuser: status[2:0].
  output logic [2:0]        m_axis_tuser,
  // RAM size configuration write channel.
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [24:0]  cfg_data_i
);

  localparam int unsigned CountW = tpdq_pkg::CountW;
  localparam int unsigned SizeW  = tpdq_pkg::SizeW;

  // Sequencer states.
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;
  localparam logic [1:0] S_RESULT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [2:0]            action_q;
  tpdq_pkg::entry_t      req_q;
  tpdq_pkg::entry_t      head_q;
  logic                  pop_q, pop_d;
  tpdq_pkg::status_e     status_q, status_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [SizeW-1:0]      ram_size_q;

  logic                  out_valid_q;
  logic [119:0]          out_data_q;
  logic [2:0]            out_user_q;

  tpdq_pkg::cell_cmd_t   cmd;
  tpdq_pkg::entry_t      chain_head;
  logic                  chain_gap;
  logic [CountW-1:0]     chain_fill;

  logic                  in_xfer;
  logic                  out_free;

  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // The user must write the configuration register only while the queue is idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_size_q <= SizeW'(25'h100_0000);
    end else if (cfg_valid_i) begin
      ram_size_q <= cfg_data_i;
    end
  end

  // Capture the request on acceptance; the row works on it in the next cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q      <= s_axis_tuser;
      req_q.tag     <= s_axis_tdata[15:0];
      req_q.owner   <= s_axis_tdata[47:16];
      req_q.dir     <= s_axis_tdata[48];
      req_q.prio    <= s_axis_tdata[49];
      req_q.src     <= s_axis_tdata[81:50];
      req_q.dst     <= s_axis_tdata[113:82];
      req_q.len     <= s_axis_tdata[138:114];
      req_q.notify  <= s_axis_tdata[139];
    end
    if (state_q == S_EXEC) begin
      head_q <= chain_head;
    end
  end

  // Sequencer: decide the row operation and the status of the item.
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    pop_d     = pop_q;
    count_d   = count_q;
    cmd.op    = tpdq_pkg::CELL_HOLD;
    cmd.entry = req_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        status_d = tpdq_pkg::STAT_OK;
        pop_d    = 1'b0;
        state_d  = S_RESULT;
        case (action_q)
          tpdq_pkg::ACT_POST: begin
            if (req_q.tag == '0) begin
              status_d = tpdq_pkg::STAT_INVALID;
            end else if (count_q == CountW'(tpdq_pkg::QueueDepth)) begin
              status_d = tpdq_pkg::STAT_FULL;
            end else begin
              cmd.op  = tpdq_pkg::CELL_INSERT;
              count_d = count_q + CountW'(1);
            end
          end
          tpdq_pkg::ACT_SERVICE: begin
            if (count_q == '0) begin
              status_d = tpdq_pkg::STAT_EMPTY;
            end else begin
              cmd.op  = tpdq_pkg::CELL_POP;
              pop_d   = 1'b1;
              count_d = count_q - CountW'(1);
            end
          end
          tpdq_pkg::ACT_REMOVE_TAG: begin
            cmd.op  = tpdq_pkg::CELL_MARK_TAG;
            state_d = S_COMPACT;
          end
          tpdq_pkg::ACT_REMOVE_OWNER: begin
            cmd.op  = tpdq_pkg::CELL_MARK_OWNER;
            state_d = S_COMPACT;
          end
          tpdq_pkg::ACT_FLUSH: begin
            cmd.op  = tpdq_pkg::CELL_CLEAR;
            count_d = '0;
          end
          default: begin
            status_d = tpdq_pkg::STAT_OK;
          end
        endcase
      end
      S_COMPACT: begin
        // Close one hole per cycle until the survivors sit at the head.
        if (chain_gap) begin
          cmd.op = tpdq_pkg::CELL_COMPACT;
        end else begin
          count_d = chain_fill;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pop_q    <= 1'b0;
      status_q <= tpdq_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pop_q    <= pop_d;
      status_q <= status_d;
    end
  end

  tpdq_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .head_o(chain_head),
    .gap_o (chain_gap),
    .fill_o(chain_fill)
  );

  // Resolve and check the popped transfer.
  logic [31:0]      ram_offset;
  logic [31:0]      host_address;
  logic             off_big;
  logic [SizeW-1:0] room;
  logic             len_big;
  logic             bad;
  logic [119:0]     res_data;
  logic [2:0]       res_user;

  assign ram_offset   = head_q.dir ? head_q.src : head_q.dst;
  assign host_address = head_q.dir ? head_q.dst : head_q.src;
  assign off_big      = ram_offset > {7'b0, ram_size_q};
  assign room         = ram_size_q - ram_offset[SizeW-1:0];
  assign len_big      = head_q.len > room;
  assign bad          = (host_address == '0) | off_big | len_big;

  always_comb begin
    res_data = '0;
    res_user = status_q;
    if (pop_q) begin
      res_user          = bad ? tpdq_pkg::STAT_BAD_XFR : tpdq_pkg::STAT_OK;
      res_data[0]       = ~bad;
      res_data[16:1]    = head_q.tag;
      res_data[17]      = head_q.dir;
      res_data[49:18]   = ram_offset;
      res_data[81:50]   = host_address;
      res_data[106:82]  = head_q.len;
      res_data[107]     = head_q.notify & ~bad;
    end
    res_data[112:108] = 5'(count_q);
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESULT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESULT && out_free) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

/* sv/tpdq_checker.sv */
// ----------------------------------------------------------------------------
// tpdq_checker: port-level checks of the DMA request queue
// Watches the result stream for consistent status, flags and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdq_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [119:0] m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Only a clean pop asks for a transfer or a completion signal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[107])
      |-> m_axis_tuser == tpdq_pkg::STAT_OK)
    else $error("transfer flagged with bad status");

  // An empty service leaves an empty queue and no payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tpdq_pkg::STAT_EMPTY
      |-> m_axis_tdata[112:108] == '0 && m_axis_tdata[107:0] == '0)
    else $error("empty service with payload or occupancy");

  // A full report comes only with a full queue; occupancy never exceeds depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[112:108] <= 5'(tpdq_pkg::QueueDepth) &&
      (m_axis_tuser != tpdq_pkg::STAT_FULL ||
       m_axis_tdata[112:108] == 5'(tpdq_pkg::QueueDepth)))
    else $error("occupancy out of range");

endmodule

bind two_priority_dma_request_queue tpdq_checker u_tpdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

/* verif/tb_two_priority_dma_request_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_priority_dma_request_queue: self-checking bench of the DMA request queue
// Runs a directed table and then random request mixes under several RAM sizes,
// predicts every result in a behavioral queue and compares it on the fly.
// ----------------------------------------------------------------------------

module tb_two_priority_dma_request_queue;

  localparam int unsigned SizeW      = tpdq_pkg::SizeW;
  localparam int unsigned CountW     = tpdq_pkg::CountW;
  localparam int unsigned QueueDepth = tpdq_pkg::QueueDepth;

  // Action codes the block leaves unused; such transfers must change nothing.
  localparam logic [2:0] ActUnusedLo = 3'd5;
  localparam logic [2:0] ActUnusedHi = 3'd7;

  localparam logic [SizeW-1:0] FullRam = 25'd16777216;

  localparam int unsigned IdlePercent    = 27;
  localparam int unsigned HoldOffCycles  = 200;
  localparam int unsigned NumPhases      = 5;
  localparam int unsigned ItemsPerPhase  = 400;
  // A removal may compact the whole row before its result shows up.
  localparam int unsigned DrainCycles    = 3 + QueueDepth + 8;
  localparam int unsigned MaxReports     = 10;
  localparam longint     TimeoutNs       = 2_000_000;

  // One request as the sender sees it, before packing onto the stream.
  typedef struct packed {
    logic [2:0]       action;
    logic [15:0]      tag;
    logic [31:0]      owner;
    logic             dir;
    logic             prio;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [SizeW-1:0] len;
    logic             notify;
  } dma_request_t;

  // One result, unpacked from the master tuser and tdata.
  typedef struct packed {
    tpdq_pkg::status_e status;
    logic             xfer_ok;
    logic [15:0]      tag;
    logic             dir;
    logic [31:0]      ram_off;
    logic [31:0]      host;
    logic [SizeW-1:0] len;
    logic             notify;
    logic [CountW-1:0] occ;
  } dma_result_t;

  // A line of the directed table. Where fixed is set, the expected result is
  // typed in the table rather than taken from the predictor.
  typedef struct packed {
    dma_request_t req;
    logic         fixed;
    dma_result_t  result;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [143:0]  s_axis_tdata  = '0;
  logic [2:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [119:0]  m_axis_tdata;
  logic [2:0]    m_axis_tuser;
  logic          cfg_valid_i   = 1'b0;
  logic          cfg_ready_o;
  logic [24:0]   cfg_data_i    = '0;

  // Predictor state: the queued requests in service order and the RAM size
  // that the bounds checks use.
  tpdq_pkg::entry_t queued_requests [$];
  logic [SizeW-1:0] ram_bytes;

  dma_result_t   expected_results [$];
  directed_row_t directed_table [$];

  int unsigned error_count        = 0;
  int unsigned requests_accepted  = 0;
  int unsigned results_checked    = 0;
  int unsigned status_tally [8];

  // Set by the stimulus to shape the receiver: steady turns idling off on
  // both sides, hold_off_pending asks for one long receiver stall.
  bit steady           = 1'b0;
  bit hold_off_pending = 1'b0;

  two_priority_dma_request_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Queue predictor. It applies one request to the behavioral queue and
  // returns the result the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic dma_result_t predict_queue_result(input dma_request_t req);
    dma_result_t      res;
    tpdq_pkg::entry_t fresh;
    tpdq_pkg::entry_t head;
    tpdq_pkg::entry_t kept [$];
    int               pos;
    longint unsigned  off;
    longint unsigned  host;
    longint unsigned  ram;
    logic             bad;
    res = '0;
    res.status = tpdq_pkg::STAT_OK;
    case (req.action)
      tpdq_pkg::ACT_POST: begin
        if (req.tag == '0) begin
          res.status = tpdq_pkg::STAT_INVALID;
        end else if (queued_requests.size() >= QueueDepth) begin
          res.status = tpdq_pkg::STAT_FULL;
        end else begin
          fresh.tag    = req.tag;
          fresh.owner  = req.owner;
          fresh.src    = req.src;
          fresh.dst    = req.dst;
          fresh.len    = req.len;
          fresh.dir    = req.dir;
          fresh.prio   = req.prio;
          fresh.notify = req.notify;
          // High priority goes behind the last queued high-priority entry.
          pos = queued_requests.size();
          if (req.prio) begin
            pos = 0;
            while (pos < queued_requests.size() && queued_requests[pos].prio) pos++;
          end
          queued_requests.insert(pos, fresh);
        end
      end
      tpdq_pkg::ACT_SERVICE: begin
        if (queued_requests.size() == 0) begin
          res.status = tpdq_pkg::STAT_EMPTY;
        end else begin
          head = queued_requests.pop_front();
          off  = head.dir ? head.src : head.dst;
          host = head.dir ? head.dst : head.src;
          ram  = ram_bytes;
          // The length check only counts once the offset is known in range.
          bad  = (host == 0) || (off > ram) || (longint'(head.len) > ram - off);
          res.status  = bad ? tpdq_pkg::STAT_BAD_XFR : tpdq_pkg::STAT_OK;
          res.xfer_ok = !bad;
          res.tag     = head.tag;
          res.dir     = head.dir;
          res.ram_off = off[31:0];
          res.host    = host[31:0];
          res.len     = head.len;
          res.notify  = bad ? 1'b0 : head.notify;
        end
      end
      tpdq_pkg::ACT_REMOVE_TAG, tpdq_pkg::ACT_REMOVE_OWNER, tpdq_pkg::ACT_FLUSH: begin
        foreach (queued_requests[i]) begin
          if (req.action == tpdq_pkg::ACT_REMOVE_TAG
              && queued_requests[i].tag != req.tag) begin
            kept.push_back(queued_requests[i]);
          end else if (req.action == tpdq_pkg::ACT_REMOVE_OWNER
                       && queued_requests[i].owner != req.owner) begin
            kept.push_back(queued_requests[i]);
          end
        end
        queued_requests = kept;
      end
      default: ;
    endcase
    res.occ = CountW'(queued_requests.size());
    return res;
  endfunction

  function automatic directed_row_t mk_row(
    input logic [2:0]  action, input logic [15:0] tag, input logic [31:0] owner,
    input logic dir, input logic prio, input logic [31:0] src, input logic [31:0] dst,
    input logic [SizeW-1:0] len, input logic notify,
    input logic fixed, input tpdq_pkg::status_e status, input logic [CountW-1:0] occ
  );
    directed_row_t row;
    row.req         = '{action, tag, owner, dir, prio, src, dst, len, notify};
    row.fixed       = fixed;
    row.result      = '0;
    row.result.status = status;
    row.result.occ  = occ;
    return row;
  endfunction

  // Random request with mostly well-formed content: tags and owners come from
  // small pools so that removals hit several entries, and addresses mostly
  // land inside the configured RAM so that serviced transfers pass the checks.
  function automatic dma_request_t random_request();
    dma_request_t req;
    int unsigned  roll;
    logic [31:0]  off;
    logic [31:0]  host;
    req.tag    = 16'($urandom);
    req.owner  = $urandom;
    req.dir    = 1'($urandom);
    req.prio   = 1'($urandom);
    req.src    = $urandom;
    req.dst    = $urandom;
    req.len    = SizeW'($urandom);
    req.notify = 1'($urandom);
    roll = $urandom_range(99);
    if (roll < 45) begin
      req.action = tpdq_pkg::ACT_POST;
      if ($urandom_range(9) < 7) req.tag = 16'($urandom_range(40, 1));
      if ($urandom_range(99) < 3) req.tag = '0;
      if ($urandom_range(9) < 7) req.owner = 32'($urandom_range(7));
      off  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'(ram_bytes));
      host = ($urandom_range(19) == 0) ? '0 : $urandom;
      if (off <= 32'(ram_bytes) && $urandom_range(99) < 80) begin
        req.len = SizeW'($urandom_range(32'(ram_bytes) - off));
      end
      {req.src, req.dst} = req.dir ? {off, host} : {host, off};
    end else if (roll < 75) begin
      req.action = tpdq_pkg::ACT_SERVICE;
    end else if (roll < 85) begin
      req.action = tpdq_pkg::ACT_REMOVE_TAG;
      req.tag = 16'($urandom_range(40, 1));
      if (queued_requests.size() != 0 && $urandom_range(9) < 8) begin
        req.tag = queued_requests[$urandom_range(queued_requests.size() - 1)].tag;
      end
    end else if (roll < 93) begin
      req.action = tpdq_pkg::ACT_REMOVE_OWNER;
      req.owner = 32'($urandom_range(7));
      if (queued_requests.size() != 0 && $urandom_range(9) < 8) begin
        req.owner = queued_requests[$urandom_range(queued_requests.size() - 1)].owner;
      end
    end else if (roll < 96) begin
      req.action = tpdq_pkg::ACT_FLUSH;
    end else if (roll < 98) begin
      req.action = 3'($urandom_range(ActUnusedHi, ActUnusedLo));
    end else begin
      // Noise: any action with fully random fields.
      req.action = 3'($urandom);
    end
    return req;
  endfunction

  // Offers one request on the slave stream, starting at a falling edge, and
  // records its expected result once the transfer is taken. It returns at a
  // falling edge with tvalid still high, so back-to-back requests never lower
  // and raise tvalid in the same step.
  task automatic issue_request(input dma_request_t req, input logic fixed,
                               input dma_result_t fixed_result);
    dma_result_t predicted;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.action;
    s_axis_tdata  <= {4'b0, req.notify, req.len, req.dst, req.src, req.prio, req.dir,
                      req.owner, req.tag};
    do @(posedge clk_i); while (!s_axis_tready);
    // The predictor runs even for typed rows so that its queue stays current.
    predicted = predict_queue_result(req);
    if (fixed) predicted = fixed_result;
    expected_results.push_back(predicted);
    status_tally[predicted.status]++;
    requests_accepted++;
    @(negedge clk_i);
  endtask

  // Lowers tvalid and waits until every outstanding result has been taken,
  // which leaves the block idle for a configuration write.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_ram_size(input logic [SizeW-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    ram_bytes = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: idles at random, runs without idling while steady is set, and
  // once stalls for a long stretch so that the block backs up onto its input.
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_pending = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every transfer on the master stream is compared field by
  // field with the oldest expected result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    dma_result_t got;
    dma_result_t want;
    string       diff;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status  = tpdq_pkg::status_e'(m_axis_tuser);
      got.xfer_ok = m_axis_tdata[0];
      got.tag     = m_axis_tdata[16:1];
      got.dir     = m_axis_tdata[17];
      got.ram_off = m_axis_tdata[49:18];
      got.host    = m_axis_tdata[81:50];
      got.len     = m_axis_tdata[106:82];
      got.notify  = m_axis_tdata[107];
      got.occ     = m_axis_tdata[112:108];
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t ns: result with none expected: %p", $time, got);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        diff = "";
        if (got.status  !== want.status)  diff = {diff, " status"};
        if (got.xfer_ok !== want.xfer_ok) diff = {diff, " transfer_valid"};
        if (got.tag     !== want.tag)     diff = {diff, " out_tag"};
        if (got.dir     !== want.dir)     diff = {diff, " out_direction"};
        if (got.ram_off !== want.ram_off) diff = {diff, " ram_offset"};
        if (got.host    !== want.host)    diff = {diff, " host_address"};
        if (got.len     !== want.len)     diff = {diff, " out_length"};
        if (got.notify  !== want.notify)  diff = {diff, " completion_notify"};
        if (got.occ     !== want.occ)     diff = {diff, " occupancy"};
        if (diff != "") begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t ns: result %0d differs in%s", $time, results_checked, diff);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table at the reset RAM size, then one
  // random phase per RAM size with a configuration write in between.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [SizeW-1:0] next_size;
    dma_request_t     req;
    int unsigned      leftover;
    ram_bytes = FullRam;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows. Typed results cover the empty queue, the null tag,
    // the occupancy after posts and removals, and the ignored action codes;
    // serviced entries go through the predictor.
    directed_table.push_back(mk_row(tpdq_pkg::ACT_SERVICE, '0, '0, 0, 0, '0, '0, '0, 0,
                                    1, tpdq_pkg::STAT_EMPTY, 0));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, '0, 32'h5, 1, 1, 32'h10, 32'h20,
                                    25'd8, 1, 1, tpdq_pkg::STAT_INVALID, 0));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_REMOVE_TAG, 16'd1, '0, 0, 0, '0, '0,
                                    '0, 0, 1, tpdq_pkg::STAT_OK, 0));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_REMOVE_OWNER, '0, '0, 0, 0, '0, '0,
                                    '0, 0, 1, tpdq_pkg::STAT_OK, 0));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_FLUSH, '0, '0, 0, 0, '0, '0, '0, 0,
                                    1, tpdq_pkg::STAT_OK, 0));
    directed_table.push_back(mk_row(ActUnusedHi, 16'hFFFF, '1, 1, 1, '1, '1, '1, 1,
                                    1, tpdq_pkg::STAT_OK, 0));
    // Two low and two high requests; the highs must come out first.
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd1, 32'h10, 0, 0,
                                    32'h8000_0000, '0, 25'd16, 1,
                                    1, tpdq_pkg::STAT_OK, 1));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd2, 32'h20, 1, 1, 32'h100, '1,
                                    25'h100, 0, 1, tpdq_pkg::STAT_OK, 2));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd3, 32'h20, 0, 1, 32'h1,
                                    32'h00FF_FFFF, 25'd1, 1,
                                    1, tpdq_pkg::STAT_OK, 3));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'hFFFF, '1, 1, 0, '1, '1, '1, 1,
                                    1, tpdq_pkg::STAT_OK, 4));
    repeat (4) begin
      directed_table.push_back(mk_row(tpdq_pkg::ACT_SERVICE, '0, '0, 0, 0, '0, '0, '0, 0,
                                      0, tpdq_pkg::STAT_OK, 0));
    end
    // A null host address, then an offset right at the end of RAM.
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd5, 32'h7, 0, 0, '0, 32'h40,
                                    25'd4, 1, 1, tpdq_pkg::STAT_OK, 1));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_SERVICE, '0, '0, 0, 0, '0, '0, '0, 0,
                                    0, tpdq_pkg::STAT_OK, 0));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd6, 32'h7, 0, 0, 32'h1234,
                                    32'h0100_0000, 25'd0, 1,
                                    1, tpdq_pkg::STAT_OK, 1));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_SERVICE, '0, '0, 0, 0, '0, '0, '0, 0,
                                    0, tpdq_pkg::STAT_OK, 0));
    // Removal by owner and by a tag that two entries share.
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd8, 32'h9, 0, 0, 32'h1, 32'h2,
                                    25'd1, 0, 1, tpdq_pkg::STAT_OK, 1));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd9, 32'h9, 1, 1, 32'h3, 32'h4,
                                    25'd1, 0, 1, tpdq_pkg::STAT_OK, 2));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd10, 32'h1, 0, 1, 32'h5, 32'h6,
                                    25'd1, 0, 1, tpdq_pkg::STAT_OK, 3));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd8, 32'h2, 1, 0, 32'h7, 32'h8,
                                    25'd1, 1, 1, tpdq_pkg::STAT_OK, 4));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_REMOVE_OWNER, '0, 32'h9, 0, 0, '0, '0,
                                    '0, 0, 1, tpdq_pkg::STAT_OK, 2));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_REMOVE_TAG, 16'd8, '0, 0, 0, '0, '0,
                                    '0, 0, 1, tpdq_pkg::STAT_OK, 1));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_POST, 16'd11, 32'h3, 0, 0, 32'h9, 32'hA,
                                    25'd2, 0, 1, tpdq_pkg::STAT_OK, 2));
    directed_table.push_back(mk_row(tpdq_pkg::ACT_FLUSH, '0, '0, 0, 0, '0, '0, '0, 0,
                                    1, tpdq_pkg::STAT_OK, 0));
    directed_table.push_back(mk_row(ActUnusedLo, 16'd12, '0, 0, 0, '0, '0, '0, 0,
                                    1, tpdq_pkg::STAT_OK, 0));

    foreach (directed_table[i]) begin
      issue_request(directed_table[i].req, directed_table[i].fixed,
                    directed_table[i].result);
    end
    drain_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       next_size = FullRam;
        1:       next_size = '0;
        2:       next_size = '1;
        3:       next_size = SizeW'($urandom_range(65535, 1));
        default: next_size = SizeW'($urandom);
      endcase
      write_ram_size(next_size);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // One long receiver stall early on, and one stretch with no idling.
        if (phase == 0 && n == 100) hold_off_pending = 1'b1;
        steady = (phase == 2 && n >= 100 && n < 400);
        req = random_request();
        issue_request(req, 1'b0, '0);
      end
      steady = 1'b0;
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    leftover = expected_results.size();
    if (leftover != 0) begin
      error_count += leftover;
      $display("%0d expected results never arrived", leftover);
    end
    $display("Checked %0d results of %0d requests under %0d RAM sizes, %0d errors.",
             results_checked, requests_accepted, NumPhases + 1, error_count);
    $display("Status mix: ok %0d, invalid %0d, full %0d, empty %0d, bad transfer %0d.",
             status_tally[tpdq_pkg::STAT_OK], status_tally[tpdq_pkg::STAT_INVALID],
             status_tally[tpdq_pkg::STAT_FULL], status_tally[tpdq_pkg::STAT_EMPTY],
             status_tally[tpdq_pkg::STAT_BAD_XFR]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("Timeout after %0d ns", TimeoutNs);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
sv/tpdq_pkg.sv
sv/tpdq_cell.sv
sv/tpdq_chain.sv
sv/two_priority_dma_request_queue.sv
sv/tpdq_checker.sv
verif/tb_two_priority_dma_request_queue.sv
